@@ sv/chs_pkg.sv @@
// Shared types, field widths and result codes for the chained hash set.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package chs_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W    = 16;
    localparam int BUCKET_W = 8;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

    // Default sizes handed to the top level
    localparam int DEF_NUM_BUCKETS = 256;
    localparam int DEF_POOL_NODES  = 1024;

    // Command and hash encodings of the item format
    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;
    localparam logic HASH_MOD  = 1'b0;
    localparam logic HASH_DIV  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_WALK
    } chs_state_t;

    // Control bits toward the bucket head store
    typedef struct packed {
        logic rd_en;
        logic we;
    } head_ctl_t;

    // Control bits toward the node store
    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic link_we;
    } node_ctl_t;

endpackage

@@ sv/chs_hash.sv @@
// Bucket hash unit: key modulo or quotient by the bucket count, by reciprocal multiply.
// Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_hash #(
    parameter int NUM_BUCKETS = chs_pkg::DEF_NUM_BUCKETS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [chs_pkg::KEY_W-1:0]      key,
    input  logic                           hash_select,
    output logic                           valid,
    output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);
    import chs_pkg::*;

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int SH = KEY_W + BW;
    localparam int PW = 2 * KEY_W + 1;

    // Reciprocal rounded up: exact quotient for every KEY_W-bit key
    localparam logic [KEY_W:0]   RECIP  = (KEY_W + 1)'(((64'd1 << SH)
                                          + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));
    localparam logic [KEY_W-1:0] NB_KEY = KEY_W'(NUM_BUCKETS);
    localparam logic [KEY_W-1:0] Q_TOP  = KEY_W'(NUM_BUCKETS - 1);
    localparam logic [BW-1:0]    B_TOP  = BW'(NUM_BUCKETS - 1);

    logic             mul_go_reg, mul_go_next;
    logic             sub_go_reg, sub_go_next;
    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             sel_reg, sel_next;
    logic [KEY_W-1:0] quo_reg, quo_next;
    logic [BW-1:0]    rem_reg, rem_next;

    logic [PW-1:0]    prod;
    logic [KEY_W-1:0] quo_back;
    logic [KEY_W-1:0] rem_full;

    // One multiply per cycle: quotient first, then multiply back and subtract
    always_comb
    begin
        prod     = PW'(key_reg) * PW'(RECIP);
        quo_back = quo_reg * NB_KEY;
        rem_full = key_reg - quo_back;
    end

    always_comb
    begin
        mul_go_next = 1'b0;
        sub_go_next = 1'b0;
        valid_next  = 1'b0;
        key_next    = key_reg;
        sel_next    = sel_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        if (start)
        begin
            mul_go_next = 1'b1;
            key_next    = key;
            sel_next    = hash_select;
        end
        if (mul_go_reg)
        begin
            quo_next    = prod[SH +: KEY_W];
            sub_go_next = 1'b1;
        end
        if (sub_go_reg)
        begin
            rem_next   = rem_full[BW-1:0];
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_go_reg <= 1'b0;
            sub_go_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            mul_go_reg <= mul_go_next;
            sub_go_reg <= sub_go_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        sel_reg <= sel_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // Saturate an out-of-range quotient to the last bucket
    assign valid  = valid_reg;
    assign bucket = (sel_reg == HASH_DIV) ? ((quo_reg >= Q_TOP) ? B_TOP : quo_reg[BW-1:0])
                                          : rem_reg;

`ifndef NO_ASSERTIONS
    a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("hash valid held longer than one cycle");

    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !(mul_go_reg || sub_go_reg))
        else $error("hash valid raised while the hash still runs");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !(mul_go_reg || sub_go_reg || valid_reg))
        else $error("hash started while a previous key is in flight");
`endif

endmodule

@@ sv/chs_head_mem.sv @@
// Bucket head store: one synchronous memory of chain heads plus a valid bit per bucket.
// Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_head_mem #(
    parameter int NUM_BUCKETS = chs_pkg::DEF_NUM_BUCKETS,
    parameter int POOL_NODES  = chs_pkg::DEF_POOL_NODES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  chs_pkg::head_ctl_t             ctl,
    input  logic [$clog2(NUM_BUCKETS)-1:0] rd_addr,
    input  logic [$clog2(NUM_BUCKETS)-1:0] wr_addr,
    input  logic [$clog2(POOL_NODES)-1:0]  wr_data,
    output logic [$clog2(POOL_NODES)-1:0]  rd_data,
    output logic                           rd_valid
);
    import chs_pkg::*;

    localparam int IW = $clog2(POOL_NODES);

    logic [IW-1:0]          head_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] valid_reg;
    logic [IW-1:0]          rd_data_reg;
    logic                   rd_valid_reg;

    // Valid bits clear at reset: an empty bucket reads as no head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.we)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            head_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg  <= head_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ sv/chs_node_mem.sv @@
// Node pool store: key and link memories sharing one read address, one write port each.
// Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_node_mem #(
    parameter int POOL_NODES = chs_pkg::DEF_POOL_NODES
) (
    input  logic                            clk,
    input  chs_pkg::node_ctl_t              ctl,
    input  logic [$clog2(POOL_NODES)-1:0]   rd_addr,
    input  logic [$clog2(POOL_NODES)-1:0]   key_addr,
    input  logic [chs_pkg::KEY_W-1:0]       key_data,
    input  logic [$clog2(POOL_NODES)-1:0]   link_addr,
    input  logic [$clog2(POOL_NODES+1)-1:0] link_data,
    output logic [chs_pkg::KEY_W-1:0]       rd_key,
    output logic [$clog2(POOL_NODES+1)-1:0] rd_link
);
    import chs_pkg::*;

    localparam int LW = $clog2(POOL_NODES + 1);

    logic [KEY_W-1:0] key_mem  [POOL_NODES];
    logic [LW-1:0]    link_mem [POOL_NODES];
    logic [KEY_W-1:0] rd_key_reg;
    logic [LW-1:0]    rd_link_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[key_addr] <= key_data;
        end
        if (ctl.link_we)
        begin
            link_mem[link_addr] <= link_data;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_link_reg <= link_mem[rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_link = rd_link_reg;

endmodule

@@ sv/chained_hash_set.sv @@
// Top level of the chained hash set: sequencer over the head and node stores.
// Depends on chs_pkg, chs_hash, chs_head_mem and chs_node_mem.
`timescale 1ns / 1ps
//
// Usage
//   Command side: drive op, key and hash_select and raise start; the beat is
//   taken at the rising edge where start is high and busy is low. busy stays
//   high until the result goes out.
//   Result side: done is high for exactly one cycle with status, bucket and
//   chain_position. The receiver cannot stall; sample the beat when done is
//   high. busy drops in that same cycle, so the next command may be taken at
//   the edge that ends the result cycle.
//   Sequence: the reciprocal multiply (quotient), the multiply back and
//   subtract (remainder), the bucket head read, the decision, then the
//   chain walk, node by node. An insert walks the whole chain, a search
//   stops at the first match, an empty bucket walks nothing.
//   Reset: every bucket starts empty (valid bits cleared at once) and the
//   node pool is free; start is taken in the first cycle after reset.
//   Accesses to one memory entry never overlap: head reads and writes fall
//   in different states, and a fresh node is written before it is linked.
//

module chained_hash_set #(
    parameter int NUM_BUCKETS = chs_pkg::DEF_NUM_BUCKETS,
    parameter int POOL_NODES  = chs_pkg::DEF_POOL_NODES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [chs_pkg::KEY_W-1:0]    key,
    input  logic                         hash_select,
    output logic                         done,
    output logic [chs_pkg::STATUS_W-1:0] status,
    output logic [chs_pkg::BUCKET_W-1:0] bucket,
    output logic [chs_pkg::POS_W-1:0]    chain_position
);
    import chs_pkg::*;

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int IW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);

    localparam logic [LW-1:0] NIL_LINK = LW'(POOL_NODES);

    chs_state_t state_reg, state_next;

    logic                op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [BW-1:0]       bucket_reg, bucket_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       fresh_reg, fresh_next;
    logic [POS_W-1:0]    step_reg, step_next;
    logic [LW-1:0]       nodes_used_reg, nodes_used_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BUCKET_W-1:0] bucket_out_reg, bucket_out_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic          hash_start;
    logic          hash_valid;
    logic [BW-1:0] hash_bucket;

    head_ctl_t     head_ctl;
    logic [IW-1:0] head_rdata;
    logic          head_rvalid;

    node_ctl_t        node_ctl;
    logic [IW-1:0]    node_rd_addr;
    logic [IW-1:0]    link_waddr;
    logic [LW-1:0]    link_wdata;
    logic [KEY_W-1:0] node_rkey;
    logic [LW-1:0]    node_rlink;

    logic             pool_full;
    logic             tail_hit;
    logic             key_hit;
    logic [POS_W-1:0] step_inc;

    assign pool_full = (nodes_used_reg == NIL_LINK);
    assign tail_hit  = (node_rlink == NIL_LINK);
    assign key_hit   = (node_rkey == key_reg);
    // Positions beyond the field range saturate
    assign step_inc  = (step_reg == POS_MAX) ? step_reg : step_reg + 1'b1;

    chs_hash #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (hash_start),
        .key        (key),
        .hash_select(hash_select),
        .valid      (hash_valid),
        .bucket     (hash_bucket)
    );

    chs_head_mem #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .POOL_NODES (POOL_NODES)
    ) u_head_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (head_ctl),
        .rd_addr (hash_bucket),
        .wr_addr (bucket_reg),
        .wr_data (nodes_used_reg[IW-1:0]),
        .rd_data (head_rdata),
        .rd_valid(head_rvalid)
    );

    chs_node_mem #(
        .POOL_NODES(POOL_NODES)
    ) u_node_mem (
        .clk      (clk),
        .ctl      (node_ctl),
        .rd_addr  (node_rd_addr),
        .key_addr (nodes_used_reg[IW-1:0]),
        .key_data (key_reg),
        .link_addr(link_waddr),
        .link_data(link_wdata),
        .rd_key   (node_rkey),
        .rd_link  (node_rlink)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_valid)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (!head_rvalid || (op_reg == OP_INSERT && pool_full))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tail_hit || (op_reg != OP_INSERT && key_hit))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        bucket_next     = bucket_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        step_next       = step_reg;
        nodes_used_next = nodes_used_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        bucket_out_next = bucket_out_reg;
        pos_next        = pos_reg;
        hash_start      = 1'b0;
        head_ctl        = '0;
        node_ctl        = '0;
        node_rd_addr    = node_rlink[IW-1:0];
        link_waddr      = cur_reg;
        link_wdata      = LW'(fresh_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    hash_start = 1'b1;
                    op_next    = op;
                    key_next   = key;
                end
            end
            S_HASH:
            begin
                // Fetch the chain head as soon as the bucket settles
                if (hash_valid)
                begin
                    head_ctl.rd_en = 1'b1;
                    bucket_next    = hash_bucket;
                end
            end
            S_HEAD:
            begin
                bucket_out_next = BUCKET_W'(bucket_reg);
                step_next       = '0;
                cur_next        = head_rdata;
                node_rd_addr    = head_rdata;
                if (op_reg == OP_INSERT)
                begin
                    if (pool_full)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        pos_next    = '0;
                    end
                    else
                    begin
                        // Allocate the fresh node as an end-of-chain entry
                        node_ctl.key_we  = 1'b1;
                        node_ctl.link_we = 1'b1;
                        link_waddr       = nodes_used_reg[IW-1:0];
                        link_wdata       = NIL_LINK;
                        fresh_next       = nodes_used_reg[IW-1:0];
                        nodes_used_next  = nodes_used_reg + 1'b1;
                        if (head_rvalid)
                        begin
                            node_ctl.rd_en = 1'b1;
                        end
                        else
                        begin
                            head_ctl.we = 1'b1;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            pos_next    = '0;
                        end
                    end
                end
                else
                begin
                    if (head_rvalid)
                    begin
                        node_ctl.rd_en = 1'b1;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        pos_next    = '0;
                    end
                end
            end
            S_WALK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (tail_hit)
                    begin
                        // Hook the fresh node onto the tail
                        node_ctl.link_we = 1'b1;
                        done_next        = 1'b1;
                        status_next      = ST_OK;
                        pos_next         = step_inc;
                    end
                    else
                    begin
                        node_ctl.rd_en = 1'b1;
                        cur_next       = node_rlink[IW-1:0];
                        step_next      = step_inc;
                    end
                end
                else
                begin
                    if (key_hit)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        pos_next    = step_reg;
                    end
                    else if (tail_hit)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        pos_next    = '0;
                    end
                    else
                    begin
                        node_ctl.rd_en = 1'b1;
                        cur_next       = node_rlink[IW-1:0];
                        step_next      = step_inc;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nodes_used_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        bucket_reg     <= bucket_next;
        cur_reg        <= cur_next;
        fresh_reg      <= fresh_next;
        step_reg       <= step_next;
        status_reg     <= status_next;
        bucket_out_reg <= bucket_out_next;
        pos_reg        <= pos_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign bucket         = bucket_out_reg;
    assign chain_position = pos_reg;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated in back-to-back cycles");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg <= NIL_LINK)
        else $error("node pool count ran past the pool size");

    a_walk_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> $past(node_ctl.rd_en))
        else $error("chain walk step without a node read issued");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
        else $error("result status is not a defined code");
`endif

endmodule

@@ bench/chained_hash_set_tb.sv @@
// Self-checking bench for chained_hash_set: inserts and searches against a
// behavioral copy of the bucket chains, with random gaps on the command side.
// Depends on chs_pkg and the chained_hash_set RTL.
`timescale 1ns / 1ps

module chained_hash_set_tb;

    import chs_pkg::*;

    localparam int NUM_BUCKETS = DEF_NUM_BUCKETS;
    localparam int POOL_NODES  = DEF_POOL_NODES;

    // End-of-chain marker in the shadow node store
    localparam int NIL_NODE = POOL_NODES;

    // Bucket that a share of the inserts is steered into, to grow one long chain
    localparam logic [BUCKET_W-1:0] HOT_BUCKET = 8'd93;

    // Worst item: longest command gap, hash and head cycles, a walk of the
    // whole pool. Allow every item that much, several times over.
    localparam int ITEM_WORST    = 16 + 16 + POOL_NODES;
    localparam int LIMIT_CYCLES  = 4 * 1300 * ITEM_WORST;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 200;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
        logic [POS_W-1:0]    chain_position;
    } hash_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                op = OP_SEARCH;
    logic [KEY_W-1:0]    key = '0;
    logic                hash_select = HASH_MOD;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [POS_W-1:0]    chain_position;

    // Shadow copy of the block's state: chain heads, node pool, fill count
    int               chain_head [NUM_BUCKETS];
    bit               chain_valid[NUM_BUCKETS];
    logic [KEY_W-1:0] pool_key   [POOL_NODES];
    int               pool_next  [POOL_NODES];
    int               pool_fill = 0;

    // Results owed by the block, oldest first
    hash_result_t     pending_results[$];
    // Every {hash_select, key} that was stored, for searches that should hit
    logic [KEY_W:0]   stored_keys[$];

    int               mismatches = 0;
    int               cycle_count = 0;

    chained_hash_set #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .POOL_NODES (POOL_NODES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .key           (key),
        .hash_select   (hash_select),
        .done          (done),
        .status        (status),
        .bucket        (bucket),
        .chain_position(chain_position)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Count and print one mismatch; stop printing after a cap, keep counting.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Apply one command to the shadow chains and return the result it owes.
    function automatic hash_result_t apply_hash_op(input logic cmd,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic sel);
        hash_result_t r;
        int           b;
        int           cur;
        int           steps;
        int           fresh;
        if (sel == HASH_MOD)
            b = int'(k) % NUM_BUCKETS;
        else
        begin
            // Saturate a quotient that runs past the last bucket
            b = int'(k) / NUM_BUCKETS;
            if (b >= NUM_BUCKETS)
                b = NUM_BUCKETS - 1;
        end
        steps = 0;
        if (cmd == OP_SEARCH)
        begin
            r.status = ST_MISS;
            cur = chain_valid[b] ? chain_head[b] : NIL_NODE;
            while (cur != NIL_NODE)
            begin
                if (pool_key[cur] == k)
                begin
                    r.status = ST_OK;
                    break;
                end
                cur = pool_next[cur];
                steps++;
            end
            // A miss reports position zero
            if (r.status == ST_MISS)
                steps = 0;
        end
        else if (pool_fill >= POOL_NODES)
        begin
            // Pool exhausted: nothing changes
            r.status = ST_FULL;
        end
        else
        begin
            r.status = ST_OK;
            fresh = pool_fill;
            pool_fill++;
            pool_key[fresh] = k;
            pool_next[fresh] = NIL_NODE;
            if (!chain_valid[b])
            begin
                chain_head[b] = fresh;
                chain_valid[b] = 1'b1;
            end
            else
            begin
                // Walk to the tail, then hang the fresh node behind it
                cur = chain_head[b];
                while (pool_next[cur] != NIL_NODE)
                begin
                    cur = pool_next[cur];
                    steps++;
                end
                pool_next[cur] = fresh;
                steps++;
            end
        end
        r.bucket = b[BUCKET_W-1:0];
        r.chain_position = (steps > int'(POS_MAX)) ? POS_MAX : steps[POS_W-1:0];
        return r;
    endfunction

    // Drive one command beat and hold it until the block takes it. Leave
    // start high on return so that a back-to-back beat needs no second
    // assignment to start in the same step.
    task automatic issue_cmd(input logic cmd, input logic [KEY_W-1:0] k, input logic sel);
        hash_result_t r;
        start       <= 1'b1;
        op          <= cmd;
        key         <= k;
        hash_select <= sel;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // Beat taken at this edge: predict now, in acceptance order
        r = apply_hash_op(cmd, k, sel);
        pending_results.push_back(r);
        if (cmd == OP_INSERT && r.status == ST_OK)
            stored_keys.push_back({sel, k});
    endtask

    // Drop start for a burst of random length, pct percent of the time.
    task automatic maybe_gap(input int pct);
        if ($urandom_range(99, 0) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clk);
        end
    endtask

    // One random beat. Inserts partly land in the hot bucket under either
    // hash; searches mostly replay a stored key, with its own hash or the
    // other one, and otherwise look up a fresh random key.
    task automatic send_random_item(input int insert_pct);
        logic [KEY_W-1:0] k;
        logic             sel;
        logic [KEY_W:0]   pick;
        int               roll;
        k    = KEY_W'($urandom);
        sel  = 1'($urandom_range(1, 0));
        roll = $urandom_range(99, 0);
        if (roll < insert_pct)
        begin
            if ($urandom_range(99, 0) < 15)
                k = (sel == HASH_MOD) ? {k[KEY_W-1:8], HOT_BUCKET} : {HOT_BUCKET, k[7:0]};
            issue_cmd(OP_INSERT, k, sel);
        end
        else
        begin
            roll = $urandom_range(99, 0);
            if (stored_keys.size() > 0 && roll < 80)
            begin
                pick = stored_keys[$urandom_range(stored_keys.size() - 1, 0)];
                k    = pick[KEY_W-1:0];
                sel  = (roll < 65) ? pick[KEY_W] : ~pick[KEY_W];
            end
            issue_cmd(OP_SEARCH, k, sel);
        end
    endtask

    // Hold the command side until every owed result has come back.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty buckets, both hashes at the key extremes, duplicates, hits at
    // several chain positions and misses caused by the wrong hash.
    task automatic test_directed();
        issue_cmd(OP_SEARCH, 16'h0000, HASH_MOD);   // empty bucket
        issue_cmd(OP_INSERT, 16'h0000, HASH_MOD);
        issue_cmd(OP_SEARCH, 16'h0000, HASH_MOD);
        issue_cmd(OP_INSERT, 16'hFFFF, HASH_DIV);   // top quotient bucket
        issue_cmd(OP_INSERT, 16'hFFFF, HASH_MOD);   // same bucket, duplicate key
        issue_cmd(OP_SEARCH, 16'hFFFF, HASH_MOD);   // first match wins
        issue_cmd(OP_INSERT, 16'h00FF, HASH_MOD);
        issue_cmd(OP_SEARCH, 16'h00FF, HASH_MOD);
        issue_cmd(OP_SEARCH, 16'h00FF, HASH_DIV);   // wrong hash, other chain
        issue_cmd(OP_INSERT, 16'h0000, HASH_DIV);   // duplicate in bucket 0
        issue_cmd(OP_INSERT, 16'h0100, HASH_MOD);
        issue_cmd(OP_INSERT, 16'h8000, HASH_MOD);
        issue_cmd(OP_SEARCH, 16'h8000, HASH_MOD);   // deepest node of bucket 0
        issue_cmd(OP_SEARCH, 16'h0100, HASH_DIV);
        issue_cmd(OP_INSERT, 16'h1234, HASH_DIV);
        issue_cmd(OP_SEARCH, 16'h1234, HASH_MOD);
        issue_cmd(OP_SEARCH, 16'h1234, HASH_DIV);
        issue_cmd(OP_SEARCH, 16'h7FFF, HASH_DIV);
        issue_cmd(OP_INSERT, 16'hAAAA, HASH_MOD);
        issue_cmd(OP_INSERT, 16'h5555, HASH_DIV);
        issue_cmd(OP_SEARCH, 16'hAAAA, HASH_MOD);
        issue_cmd(OP_SEARCH, 16'h5555, HASH_DIV);
    endtask

    // Mixed traffic; switch between gappy and back-to-back stretches.
    task automatic test_random_traffic();
        int gap_pct;
        gap_pct = 0;
        for (int i = 0; i < 200; i++)
        begin
            if (i % 40 == 0)
                gap_pct = $urandom_range(1, 0) ? 40 : 0;
            send_random_item(65);
            maybe_gap(gap_pct);
        end
    endtask

    // Let the block go fully idle, then resume with back-to-back beats.
    task automatic test_drain_pause();
        wait_results_drained();
        for (int i = 0; i < 10; i++)
            send_random_item(50);
    endtask

    // Mostly inserts until the shadow pool is full.
    task automatic test_fill_pool();
        while (pool_fill < POOL_NODES)
        begin
            send_random_item(95);
            maybe_gap(25);
        end
    endtask

    // Inserts into a full pool plus searches, with no gaps at all.
    task automatic test_full_pool();
        issue_cmd(OP_INSERT, 16'h0000, HASH_MOD);
        issue_cmd(OP_INSERT, 16'hFFFF, HASH_DIV);
        for (int i = 0; i < 60; i++)
            send_random_item(30);
    endtask

    // Check each result beat against the oldest owed result.
    always @(posedge clk)
    begin : check_results
        hash_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none owed", 32'(status), 32'(0));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (bucket !== want.bucket)
                    report_mismatch("bucket", 32'(bucket), 32'(want.bucket));
                if (chain_position !== want.chain_position)
                    report_mismatch("chain_position", 32'(chain_position),
                                    32'(want.chain_position));
            end
        end
    end

    // Watchdog: abort a run that overruns the cycle budget.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("chained_hash_set test failed");
        $finish;
    end

    initial
    begin
        // Hold reset, then release it on a rising edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_drain_pause();
        test_fill_pool();
        test_full_pool();

        // Drain, then watch a while longer for stray result beats
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("chained_hash_set test passed");
        else
            $display("chained_hash_set test failed");
        $finish;
    end

endmodule
